@@ hdl/scpfc_pkg.sv @@
// Package for the swapchain pixel format converter: mode and register codes,
// pipeline types and the threshold tables built at elaboration.
// Depends on nothing; every other file of the block imports it.
package scpfc_pkg;

    localparam int CHAN_W       = 10;
    localparam int BYTE_W       = 8;
    localparam int HALF_W       = 16;
    localparam int KEY_W        = 25;
    localparam int SEARCH_STEPS = 8;
    localparam int NUM_STAGES   = SEARCH_STEPS + 1;
    localparam int TAB_DEPTH    = 256;
    localparam int TONE_W       = 11;
    localparam int LIN_BYTES    = 10;
    localparam int LIN_W        = 16;
    localparam int WIDE_W       = 360;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 2;

    localparam logic [1:0] MODE_BGRA8   = 2'd0;
    localparam logic [1:0] MODE_HDR10   = 2'd1;
    localparam logic [1:0] MODE_RGBA16F = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SDR_TONEMAP = 2'd1;

    localparam logic [4:0]       EXP_SPECIAL = 5'd31;
    localparam logic [14:0]      HALF_ONE    = 15'h3c00;
    localparam logic [KEY_W-1:0] X_ONE       = 25'h100_0000;
    localparam logic [KEY_W-1:0] LIN_MAX     = KEY_W'((64'd31308 << 24) / 64'd10000000);
    localparam logic [CHAN_W-1:0] BYTE_FULL  = 10'd255;

    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [TAB_DEPTH-1:0][KEY_W-1:0] srgb_tab_t;
    typedef logic [TAB_DEPTH-1:0][TONE_W-1:0] tone_tab_t;
    typedef logic [LIN_BYTES-1:0][LIN_W-1:0] lin_tab_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              sel_tone;
        logic              search;
        logic [CHAN_W-1:0] val;
    } lane_stage_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    function automatic wide_t wide_pow(wide_t base, int unsigned n);
        wide_t r;
        r = WIDE_W'(1);
        for (int unsigned i = 0; i < n; i++)
        begin
            r = r * base;
        end
        return r;
    endfunction

    // Smallest linear value X (scaled by 2^24) whose sRGB byte reaches k.
    function automatic logic [KEY_W-1:0] srgb_threshold(int unsigned k);
        wide_t            c;
        wide_t            rhs;
        wide_t            lhs;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        logic [KEY_W-1:0] mid;
        c   = wide_pow(WIDE_W'(269025), 12);
        rhs = wide_pow(WIDE_W'(1000 * k + 14025), 12) << 120;
        lo  = '0;
        hi  = X_ONE;
        while (lo < hi)
        begin
            mid = KEY_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
            lhs = wide_pow(WIDE_W'(mid), 5) * c;
            if (lhs >= rhs)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + KEY_W'(1);
            end
        end
        return hi;
    endfunction

    // Smallest 10-bit channel value whose tone-mapped byte reaches k.
    function automatic logic [TONE_W-1:0] tone_threshold(int unsigned k);
        logic [63:0]       goal;
        logic [TONE_W-1:0] lo;
        logic [TONE_W-1:0] hi;
        logic [TONE_W-1:0] mid;
        goal = 64'(k) * 64'd1690000;
        lo   = '0;
        hi   = TONE_W'(1024);
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (64'(mid) * 64'(mid) * 64'd1020 >= goal)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + TONE_W'(1);
            end
        end
        return hi;
    endfunction

    function automatic srgb_tab_t build_srgb_tab();
        srgb_tab_t t;
        for (int unsigned k = 0; k < TAB_DEPTH; k++)
        begin
            t[k] = srgb_threshold(k);
        end
        return t;
    endfunction

    function automatic tone_tab_t build_tone_tab();
        tone_tab_t t;
        for (int unsigned k = 0; k < TAB_DEPTH; k++)
        begin
            t[k] = tone_threshold(k);
        end
        return t;
    endfunction

    // Entry j holds the smallest X whose linear-segment byte reaches j + 1.
    function automatic lin_tab_t build_lin_tab();
        lin_tab_t t;
        for (int unsigned j = 0; j < LIN_BYTES; j++)
        begin
            t[j] = LIN_W'((64'(j + 1) * 64'd167772160 + 64'd32945) / 64'd32946);
        end
        return t;
    endfunction

    localparam srgb_tab_t SRGB_TAB = build_srgb_tab();
    localparam tone_tab_t TONE_TAB = build_tone_tab();
    localparam lin_tab_t  LIN_TAB  = build_lin_tab();

endpackage

@@ hdl/scpfc_ctrl.sv @@
// Pipeline control for the pixel converter: per-stage valid bits, the
// load enables for every lane, and the last-pixel flag. Uses scpfc_pkg.
module scpfc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   last_pixel,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   last_out,
    output scpfc_pkg::pipe_ctrl_t  ctrl
);
    import scpfc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] last_reg;
    logic [NUM_STAGES-1:0] last_next;
    logic [NUM_STAGES-1:0] load;

    // A stage loads when it is empty or its request moves on this cycle.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        last_next  = last_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
            last_next[0]  = last_pixel;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
                last_next[i]  = last_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    assign ctrl.load = load;
    assign in_stall  = !load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign last_out  = last_reg[NUM_STAGES-1];

endmodule

@@ hdl/scpfc_lane.sv @@
// One channel lane of the pixel converter: format decode followed by an
// eight-step threshold search pipeline. Uses the tables of scpfc_pkg.
module scpfc_lane (
    input  logic                          clk,
    input  scpfc_pkg::pipe_ctrl_t         ctrl,
    input  logic [1:0]                    pixel_mode,
    input  logic                          sdr_tonemap,
    input  logic [scpfc_pkg::BYTE_W-1:0]  byte_val,
    input  logic [scpfc_pkg::CHAN_W-1:0]  hdr_val,
    input  logic [scpfc_pkg::HALF_W-1:0]  half_val,
    output logic [scpfc_pkg::CHAN_W-1:0]  chan
);
    import scpfc_pkg::*;

    lane_stage_t      decoded;
    lane_stage_t      stage_reg  [NUM_STAGES];
    lane_stage_t      stage_next [NUM_STAGES];
    logic [4:0]       half_exp;
    logic [9:0]       half_man;
    logic [KEY_W-1:0] half_x;
    logic [3:0]       lin_byte;

    assign half_exp = half_val[14:10];
    assign half_man = half_val[9:0];

    always_comb
    begin
        if (half_val[14:0] >= HALF_ONE)
        begin
            half_x = X_ONE;
        end
        else if (half_exp == 5'd0)
        begin
            half_x = KEY_W'(half_man);
        end
        else
        begin
            half_x = KEY_W'({1'b1, half_man}) << 4'(half_exp - 5'd1);
        end
    end

    always_comb
    begin
        lin_byte = '0;
        for (int j = 0; j < LIN_BYTES; j++)
        begin
            lin_byte = lin_byte + {3'b000, (half_x >= KEY_W'(LIN_TAB[j]))};
        end
    end

    always_comb
    begin
        decoded = '{key: half_x, sel_tone: 1'b0, search: 1'b0, val: '0};
        unique case (pixel_mode)
            MODE_HDR10:
            begin
                if (sdr_tonemap)
                begin
                    decoded.key      = KEY_W'(hdr_val);
                    decoded.sel_tone = 1'b1;
                    decoded.search   = 1'b1;
                end
                else
                begin
                    decoded.val = hdr_val;
                end
            end
            MODE_RGBA16F:
            begin
                if (half_val[15])
                begin
                    decoded.val = '0;
                end
                else if (half_exp == EXP_SPECIAL)
                begin
                    decoded.val = (half_man == 10'd0) ? BYTE_FULL : '0;
                end
                else if (half_x <= LIN_MAX)
                begin
                    decoded.val = CHAN_W'(lin_byte);
                end
                else
                begin
                    decoded.search = 1'b1;
                end
            end
            default:
            begin
                decoded.val = CHAN_W'(byte_val);
            end
        endcase
    end

    // Each step tries the next lower bit of the byte against its threshold.
    always_comb
    begin
        logic [BYTE_W-1:0] mid;
        logic [KEY_W-1:0]  thr;
        stage_next[0] = decoded;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            stage_next[i] = stage_reg[i-1];
            mid = stage_reg[i-1].val[BYTE_W-1:0] | (8'd1 << (SEARCH_STEPS - i));
            thr = stage_reg[i-1].sel_tone ? KEY_W'(TONE_TAB[mid]) : SRGB_TAB[mid];
            if (stage_reg[i-1].search && (stage_reg[i-1].key >= thr))
            begin
                stage_next[i].val = CHAN_W'(mid);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (ctrl.load[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign chan = stage_reg[NUM_STAGES-1].val;

endmodule

@@ hdl/swapchain_pixel_format_converter_top.sv @@
// Each pixel request is registered in the decode stage and then in each of the eight threshold
// step stages, and the last of these drives the outputs.
// Throughput: one pixel per cycle while the output is not stalled; all stages are pipelined.
// Stalls on the output side back up stage by stage, so empty stages still take requests.
// Reset clears all stage valid bits and sets pixel_mode to 0 and sdr_tonemap to 1.
// Holds the configuration registers, three scpfc_lane copies and scpfc_ctrl;
// depends on scpfc_pkg.
module swapchain_pixel_format_converter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scpfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scpfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [63:0]                       pixel_word,
    input  logic                              last_pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [scpfc_pkg::CHAN_W-1:0]      chan_first,
    output logic [scpfc_pkg::CHAN_W-1:0]      chan_second,
    output logic [scpfc_pkg::CHAN_W-1:0]      chan_third,
    output logic                              last_out
);
    import scpfc_pkg::*;

    logic [1:0]  pixel_mode_reg;
    logic [1:0]  pixel_mode_next;
    logic        sdr_tonemap_reg;
    logic        sdr_tonemap_next;
    pipe_ctrl_t  ctrl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pixel_mode_next  = pixel_mode_reg;
        sdr_tonemap_next = sdr_tonemap_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PIXEL_MODE:
                begin
                    pixel_mode_next = cfg_data[1:0];
                end
                REG_SDR_TONEMAP:
                begin
                    sdr_tonemap_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg  <= MODE_BGRA8;
            sdr_tonemap_reg <= 1'b1;
        end
        else
        begin
            pixel_mode_reg  <= pixel_mode_next;
            sdr_tonemap_reg <= sdr_tonemap_next;
        end
    end

    scpfc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_pixel (last_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .last_out   (last_out),
        .ctrl       (ctrl)
    );

    scpfc_lane u_lane_first (
        .clk         (clk),
        .ctrl        (ctrl),
        .pixel_mode  (pixel_mode_reg),
        .sdr_tonemap (sdr_tonemap_reg),
        .byte_val    (pixel_word[23:16]),
        .hdr_val     (pixel_word[9:0]),
        .half_val    (pixel_word[15:0]),
        .chan        (chan_first)
    );

    scpfc_lane u_lane_second (
        .clk         (clk),
        .ctrl        (ctrl),
        .pixel_mode  (pixel_mode_reg),
        .sdr_tonemap (sdr_tonemap_reg),
        .byte_val    (pixel_word[15:8]),
        .hdr_val     (pixel_word[19:10]),
        .half_val    (pixel_word[31:16]),
        .chan        (chan_second)
    );

    scpfc_lane u_lane_third (
        .clk         (clk),
        .ctrl        (ctrl),
        .pixel_mode  (pixel_mode_reg),
        .sdr_tonemap (sdr_tonemap_reg),
        .byte_val    (pixel_word[7:0]),
        .hdr_val     (pixel_word[29:20]),
        .half_val    (pixel_word[47:32]),
        .chan        (chan_third)
    );

endmodule

@@ sim/tb_swapchain_pixel_format_converter_top.sv @@
// Self-checking testbench for swapchain_pixel_format_converter_top: directed and random
// pixel requests in every mode, checked against an in-bench predictor of the conversion.
// Depends on scpfc_pkg and the RTL of the converter only.
`timescale 1ns / 1ps

module tb_swapchain_pixel_format_converter_top;
    import scpfc_pkg::*;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_B = 2'd3;
    localparam logic [CFG_DATA_W-1:0] MODE_SPARE  = 2'd3;
    localparam int unsigned           CYCLE_LIMIT = 300000;
    localparam int unsigned           SETTLE_CYCLES = 12;
    localparam int unsigned           HOLD_CYCLES = 80;

    typedef logic [399:0] huge_t;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } pixel_req_t;

    typedef struct {
        logic [CHAN_W-1:0] first;
        logic [CHAN_W-1:0] second;
        logic [CHAN_W-1:0] third;
        logic              last;
    } chan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [63:0]           pixel_word = '0;
    logic                  last_pixel = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAN_W-1:0]     chan_first;
    logic [CHAN_W-1:0]     chan_second;
    logic [CHAN_W-1:0]     chan_third;
    logic                  last_out;

    pixel_req_t    pixel_pending[$];
    chan_result_t  chan_expect[$];
    logic [1:0]    mode_now = MODE_BGRA8;
    logic          tone_now = 1'b1;
    bit            idle_on = 1'b0;
    bit            hold_arm = 1'b0;
    logic          long_hold = 1'b0;
    int unsigned   send_gap = 0;
    int unsigned   stall_left = 0;
    int unsigned   bad_count = 0;
    int unsigned   cycle_count = 0;

    swapchain_pixel_format_converter_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_word  (pixel_word),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .chan_first  (chan_first),
        .chan_second (chan_second),
        .chan_third  (chan_third),
        .last_out    (last_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic huge_t raise(huge_t b, int unsigned n);
        huge_t acc;
        acc = huge_t'(1);
        repeat (n) acc = acc * b;
        return acc;
    endfunction

    // Negative values and NaN give zero; the linear segment is taken below 0.0031308,
    // otherwise the byte is found by comparing fifth powers against twelfth powers.
    function automatic logic [CHAN_W-1:0] srgb_byte_of_half(logic [HALF_W-1:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [24:0] x;
        huge_t       lhs;
        huge_t       rhs;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        ex  = h[14:10];
        man = h[9:0];
        if (h[15])
            return '0;
        if (ex == EXP_SPECIAL)
            return (man != 0) ? '0 : BYTE_FULL;
        if (h >= 16'h3c00)
            x = 25'd1 << 24;
        else if (ex == 5'd0)
            x = 25'(man);
        else
            x = 25'({1'b1, man}) << (ex - 5'd1);
        if (64'(x) * 64'd10000000 <= (64'd31308 << 24))
            return CHAN_W'((64'(x) * 64'd32946) / (64'd10 << 24));
        lhs = raise(huge_t'(x), 5) * raise(huge_t'(269025), 12);
        lo  = 0;
        hi  = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            rhs = raise(huge_t'(1000 * mid + 14025), 12) << 120;
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return CHAN_W'(lo);
    endfunction

    function automatic logic [CHAN_W-1:0] tone_byte(logic [9:0] v);
        logic [63:0] t;
        t = 64'(v) * 64'(v) * 64'd1020 / 64'd1690000;
        return (t > 64'd255) ? BYTE_FULL : CHAN_W'(t);
    endfunction

    function automatic chan_result_t convert_pixel(logic [63:0] w, logic last,
                                                   logic [1:0] mode, logic tone);
        chan_result_t r;
        r.last = last;
        case (mode)
            MODE_HDR10:
            begin
                r.first  = w[9:0];
                r.second = w[19:10];
                r.third  = w[29:20];
                if (tone)
                begin
                    r.first  = tone_byte(w[9:0]);
                    r.second = tone_byte(w[19:10]);
                    r.third  = tone_byte(w[29:20]);
                end
            end
            MODE_RGBA16F:
            begin
                r.first  = srgb_byte_of_half(w[15:0]);
                r.second = srgb_byte_of_half(w[31:16]);
                r.third  = srgb_byte_of_half(w[47:32]);
            end
            default:
            begin
                r.first  = CHAN_W'(w[23:16]);
                r.second = CHAN_W'(w[15:8]);
                r.third  = CHAN_W'(w[7:0]);
            end
        endcase
        return r;
    endfunction

    function automatic int unsigned pause_draw();
        return idle_on ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic logic [HALF_W-1:0] pick_half();
        case ($urandom_range(0, 5))
            0: return HALF_W'($urandom);
            1: return HALF_W'($urandom_range(0, 16'h3c00));
            2: return HALF_W'($urandom_range(0, 16'h1c00));
            3: return HALF_W'($urandom_range(16'h1a60, 16'h1a70));
            4:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'h7c00;
                    1: return 16'h7e00 | HALF_W'($urandom_range(0, 16'h1ff));
                    2: return 16'h8000 | HALF_W'($urandom);
                    3: return 16'h3c00 + HALF_W'($urandom_range(0, 16'h3ff));
                    4: return 16'h0000;
                    default: return 16'h3bff;
                endcase
            end
            default: return HALF_W'($urandom_range(16'h3000, 16'h3c00));
        endcase
    endfunction

    function automatic logic [9:0] pick_chan10();
        case ($urandom_range(0, 3))
            0: return 10'($urandom_range(640, 660));
            1: return ($urandom_range(0, 1) != 0) ? 10'h3ff : 10'h000;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] make_pixel(logic [1:0] mode);
        if ($urandom_range(0, 6) == 0)
            return {$urandom, $urandom};
        case (mode)
            MODE_HDR10:
                return {$urandom, 2'($urandom), pick_chan10(), pick_chan10(), pick_chan10()};
            MODE_RGBA16F:
                return {16'($urandom), pick_half(), pick_half(), pick_half()};
            default:
                return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_pixel(input logic [63:0] w, input logic last);
        pixel_req_t p;
        p.word = w;
        p.last = last;
        pixel_pending.push_back(p);
    endtask

    task automatic settle();
        @(posedge clk);
        while (pixel_pending.size() != 0 || in_valid || chan_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : drive
        pixel_req_t next_req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pixel_pending.size() != 0)
            begin
                next_req = pixel_pending.pop_front();
                in_valid   <= 1'b1;
                pixel_word <= next_req.word;
                last_pixel <= next_req.last;
                send_gap   <= pause_draw();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : predict
        if (!rst_n)
        begin
            mode_now <= MODE_BGRA8;
            tone_now <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PIXEL_MODE)
                    mode_now <= cfg_data;
                else if (cfg_index == REG_SDR_TONEMAP)
                    tone_now <= cfg_data[0];
            end
            if (in_valid && !in_stall)
                chan_expect.push_back(convert_pixel(pixel_word, last_pixel, mode_now, tone_now));
        end
    end

    always @(posedge clk)
    begin : watch_out
        chan_result_t want;
        int unsigned  nxt;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            nxt = stall_left;
            if (out_valid && !out_stall)
            begin
                if (chan_expect.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected result %0d %0d %0d last %0b", $realtime,
                                 chan_first, chan_second, chan_third, last_out);
                end
                else
                begin
                    want = chan_expect.pop_front();
                    if (chan_first !== want.first || chan_second !== want.second ||
                        chan_third !== want.third || last_out !== want.last)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("%0t: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                                     $realtime, want.first, want.second, want.third, want.last,
                                     chan_first, chan_second, chan_third, last_out);
                    end
                end
                nxt = pause_draw();
            end
            else if (nxt != 0)
            begin
                nxt = nxt - 1;
            end
            stall_left <= nxt;
            out_stall  <= long_hold || (nxt != 0);
        end
    end

    // The receiver refuses results for a long stretch so that the pipeline fills
    // and the block pushes back on new requests.
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_swapchain_pixel_format_converter_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] mode_pick;
        logic [1:0] tone_pick;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_pixel(64'h0, 1'b0);
        push_pixel(64'hffff_ffff_ffff_ffff, 1'b1);
        push_pixel(64'h1234_5678_a5c3_96e1, 1'b0);
        settle();

        set_reg(REG_PIXEL_MODE, MODE_HDR10);
        push_pixel(64'hffff_ffff_0000_0000, 1'b0);
        push_pixel(64'hffff_ffff_ffff_ffff, 1'b1);
        push_pixel({32'h0, 2'b11, 10'd1023, 10'd649, 10'd650}, 1'b0);
        settle();

        set_reg(REG_SDR_TONEMAP, 2'd0);
        push_pixel(64'hffff_ffff_ffff_ffff, 1'b0);
        push_pixel({32'h0, 2'b01, 10'd512, 10'd1, 10'd0}, 1'b1);
        settle();

        set_reg(REG_PIXEL_MODE, MODE_RGBA16F);
        set_reg(REG_SDR_TONEMAP, 2'd1);
        push_pixel({16'hffff, 16'h3c00, 16'h0000, 16'h8000}, 1'b0);
        push_pixel({16'h0000, 16'hfe00, 16'h7e00, 16'h7c00}, 1'b0);
        push_pixel({16'h3c00, 16'h7bff, 16'h3c01, 16'hbc00}, 1'b1);
        push_pixel({16'h7e00, 16'h1a6a, 16'h1a69, 16'h0001}, 1'b0);
        push_pixel({16'h0000, 16'hfc00, 16'h03ff, 16'h3bff}, 1'b1);
        settle();

        // Index values past the register list must leave both registers alone,
        // and tone-map data is cut to its single bit.
        set_reg(REG_PIXEL_MODE, MODE_SPARE);
        set_reg(REG_SDR_TONEMAP, 2'd2);
        set_reg(REG_SPARE_A, 2'd1);
        set_reg(REG_SPARE_B, 2'd2);
        push_pixel(64'hffff_ffff_ffff_ffff, 1'b0);
        push_pixel(64'h8421_0f0f_c3a5_5a3c, 1'b1);
        settle();

        for (int p = 0; p < 12; p++)
        begin
            mode_pick = 2'($urandom_range(0, 3));
            tone_pick = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1) != 0)
            begin
                set_reg(REG_PIXEL_MODE, mode_pick);
                set_reg(REG_SDR_TONEMAP, tone_pick);
            end
            else
            begin
                set_reg(REG_SDR_TONEMAP, tone_pick);
                set_reg(REG_PIXEL_MODE, mode_pick);
            end
            if ($urandom_range(0, 3) == 0)
                set_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 2'($urandom));
            idle_on = (p % 3) != 1;
            if (p == 5)
            begin
                idle_on  = 1'b0;
                hold_arm = 1'b1;
            end
            repeat (58) push_pixel(make_pixel(mode_pick), $urandom_range(0, 7) == 0);
            settle();
        end

        if (bad_count == 0 && chan_expect.size() == 0)
            $display("tb_swapchain_pixel_format_converter_top: done, clean");
        else
            $display("tb_swapchain_pixel_format_converter_top: done, errors");
        $finish;
    end

endmodule
